### rtl/point_mass_gravity_accel_unit_defines.svh
// assertion macros for the point mass gravity acceleration unit
`ifndef POINT_MASS_GRAVITY_ACCEL_UNIT_DEFINES_SVH
`define POINT_MASS_GRAVITY_ACCEL_UNIT_DEFINES_SVH

`ifndef SYNTHESIS

`define PMGA_ASSERT_IMPL(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("pmga check failed");

`define PMGA_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("pmga check failed");

`else

`define PMGA_ASSERT_IMPL(label, clk, rst, ante, cons)

`define PMGA_ASSERT_NEXT(label, clk, rst, ante, cons)

`endif

`endif

### rtl/pmga_pkg.sv
// shared widths, constants and pipeline record types for the gravity unit
package pmga_pkg;

   localparam int POS_BITS   = 32;
   localparam int FRAC_BITS  = 16;
   localparam int MU_BITS    = 50;
   localparam int MU_SPLIT   = 25;
   localparam int MU_HI_BITS = MU_BITS - MU_SPLIT;
   localparam int R2_BITS    = 2 * POS_BITS;
   localparam int HALF_BITS  = R2_BITS / 2;
   localparam int ROOT_BITS  = POS_BITS;
   localparam int R3_BITS    = R2_BITS + ROOT_BITS;
   localparam int NUM_BITS   = MU_BITS + POS_BITS + FRAC_BITS;
   localparam int ACC_BITS   = 32;
   localparam int Q_BITS     = ACC_BITS;
   localparam int D_BITS     = R3_BITS + Q_BITS;
   localparam int SQRT_STAGES = R2_BITS / 2;
   localparam int DIV_STAGES  = Q_BITS + 1;
   localparam int PART_BITS   = POS_BITS + MU_SPLIT;

   localparam logic [MU_BITS-1:0] MU_RESET = MU_BITS'(64'd398600441800000);

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic                zero_x;
      logic                zero_y;
      logic [R2_BITS-1:0]  r2;
      logic [R2_BITS-1:0]  rem;
      logic [R2_BITS-1:0]  root;
      logic [NUM_BITS-1:0] num_x;
      logic [NUM_BITS-1:0] num_y;
   } sq_type;

   typedef struct packed {
      logic                neg_x;
      logic                neg_y;
      logic                zero_x;
      logic                zero_y;
      logic [R3_BITS-1:0]  r3;
      logic [NUM_BITS-1:0] rem_x;
      logic [NUM_BITS-1:0] rem_y;
      logic [Q_BITS-1:0]   q_x;
      logic [Q_BITS-1:0]   q_y;
      logic                ovf_x;
      logic                ovf_y;
   } dv_type;

endpackage

### rtl/pmga_sqrt_pipe.sv
// pipelined integer square root of r squared, one result bit per stage
module pmga_sqrt_pipe (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  pmga_pkg::sq_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output pmga_pkg::sq_type out_data
);
   import pmga_pkg::*;

   function automatic sq_type sqrt_step(sq_type d, int k);
      logic [R2_BITS-1:0] one;
      logic [R2_BITS-1:0] trial;
      sq_type r;
      r = d;
      one = R2_BITS'(1) << (R2_BITS - 2 - 2 * k);
      trial = d.root + one;
      if (d.rem >= trial) begin
         r.rem = d.rem - trial;
         r.root = (d.root >> 1) + one;
      end else begin
         r.root = d.root >> 1;
      end
      return r;
   endfunction

   logic [SQRT_STAGES-1:0] valid_ff;
   logic [SQRT_STAGES-1:0] valid_in;
   logic [SQRT_STAGES-1:0] en;
   sq_type data_ff [SQRT_STAGES];
   sq_type data_in [SQRT_STAGES];

   genvar k;
   generate
      for (k = 0; k < SQRT_STAGES; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign data_in[k]  = sqrt_step(in_data, k);
         end else begin : g_rest
            assign valid_in[k] = valid_ff[k-1];
            assign data_in[k]  = sqrt_step(data_ff[k-1], k);
         end
         if (k == SQRT_STAGES - 1) begin : g_last
            assign en[k] = !valid_ff[k] || out_ready;
         end else begin : g_mid
            assign en[k] = !valid_ff[k] || en[k+1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               data_ff[k] <= data_in[k];
            end
         end
      end
   endgenerate

   assign in_ready  = en[0];
   assign out_valid = valid_ff[SQRT_STAGES-1];
   assign out_data  = data_ff[SQRT_STAGES-1];

endmodule

### rtl/pmga_div_pipe.sv
// pipelined restoring division of mu times position by r cubed, both axes
module pmga_div_pipe (
   input  logic            clock,
   input  logic            reset,
   input  logic            in_valid,
   output logic            in_ready,
   input  pmga_pkg::dv_type in_data,
   output logic            out_valid,
   input  logic            out_ready,
   output pmga_pkg::dv_type out_data
);
   import pmga_pkg::*;

   // first stage checks for a quotient of 2^32 or more, the rest give one bit each
   function automatic dv_type div_step(dv_type d, int j);
      logic [D_BITS-1:0] dsr;
      logic [D_BITS-1:0] rx;
      logic [D_BITS-1:0] ry;
      dv_type r;
      r = d;
      dsr = {d.r3, Q_BITS'(0)} >> j;
      rx = D_BITS'(d.rem_x);
      ry = D_BITS'(d.rem_y);
      if (j == 0) begin
         r.ovf_x = rx >= dsr;
         r.ovf_y = ry >= dsr;
      end else begin
         if (rx >= dsr) begin
            r.rem_x = NUM_BITS'(rx - dsr);
            r.q_x[Q_BITS-j] = 1'b1;
         end
         if (ry >= dsr) begin
            r.rem_y = NUM_BITS'(ry - dsr);
            r.q_y[Q_BITS-j] = 1'b1;
         end
      end
      return r;
   endfunction

   logic [DIV_STAGES-1:0] valid_ff;
   logic [DIV_STAGES-1:0] valid_in;
   logic [DIV_STAGES-1:0] en;
   dv_type data_ff [DIV_STAGES];
   dv_type data_in [DIV_STAGES];

   genvar k;
   generate
      for (k = 0; k < DIV_STAGES; k++) begin : g_stage
         if (k == 0) begin : g_first
            assign valid_in[k] = in_valid;
            assign data_in[k]  = div_step(in_data, k);
         end else begin : g_rest
            assign valid_in[k] = valid_ff[k-1];
            assign data_in[k]  = div_step(data_ff[k-1], k);
         end
         if (k == DIV_STAGES - 1) begin : g_last
            assign en[k] = !valid_ff[k] || out_ready;
         end else begin : g_mid
            assign en[k] = !valid_ff[k] || en[k+1];
         end

         always_ff @(posedge clock) begin
            if (reset) begin
               valid_ff[k] <= 1'b0;
            end else if (en[k]) begin
               valid_ff[k] <= valid_in[k];
            end
         end

         always_ff @(posedge clock) begin
            if (en[k]) begin
               data_ff[k] <= data_in[k];
            end
         end
      end
   endgenerate

   assign in_ready  = en[0];
   assign out_valid = valid_ff[DIV_STAGES-1];
   assign out_data  = data_ff[DIV_STAGES-1];

endmodule

### rtl/point_mass_gravity_accel_unit.sv
// top level: point mass gravity acceleration, fully pipelined
// throughput: one position per cycle; each stage advances while the next one has room
// the 32-stage root and 33-stage divider make up most of the latency
// reset: synchronous, clears all stage valid bits and loads mu with its default
`include "point_mass_gravity_accel_unit_defines.svh"
module point_mass_gravity_accel_unit (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          csr_valid,
   output logic                          csr_ready,
   input  logic [pmga_pkg::MU_BITS-1:0]  csr_data,   // grav_param
   input  logic                          req_tvalid,
   output logic                          req_tready,
   input  logic [2*pmga_pkg::POS_BITS-1:0] req_tdata, // pos_x, pos_y
   output logic                          rsp_tvalid,
   input  logic                          rsp_tready,
   output logic [2*pmga_pkg::ACC_BITS-1:0] rsp_tdata, // accel_x, accel_y
   output logic [1:0]                    rsp_tuser   // at_origin, saturated
);
   import pmga_pkg::*;

   logic [MU_BITS-1:0] grav_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         grav_ff <= MU_RESET;
      end else if (csr_valid) begin
         grav_ff <= csr_data;
      end
   end

   assign csr_ready = 1'b1;

   // stage a1: magnitudes and signs
   logic                a1_valid_ff;
   logic                a1_en;
   logic                a1_neg_x_ff, a1_neg_y_ff;
   logic [POS_BITS-1:0] a1_mag_x_ff, a1_mag_y_ff;
   logic [POS_BITS-1:0] raw_x, raw_y;

   // stage a2: squares and mu partial products
   logic                 a2_valid_ff;
   logic                 a2_en;
   logic                 a2_neg_x_ff, a2_neg_y_ff, a2_zero_x_ff, a2_zero_y_ff;
   logic [R2_BITS-1:0]   a2_sq_x_ff, a2_sq_y_ff;
   logic [PART_BITS-1:0] a2_px_lo_ff, a2_px_hi_ff, a2_py_lo_ff, a2_py_hi_ff;

   // stage a3: r squared and numerators
   logic   a3_valid_ff;
   logic   a3_en;
   sq_type a3_data_ff;
   sq_type a3_data_in;

   logic   sq_in_ready, sq_out_valid, sq_out_ready;
   sq_type sq_out_data;

   // stages m1 and m2: r cubed
   logic                m1_valid_ff;
   logic                m1_en;
   logic                m1_neg_x_ff, m1_neg_y_ff, m1_zero_x_ff, m1_zero_y_ff;
   logic [R2_BITS-1:0]  m1_p_lo_ff, m1_p_hi_ff;
   logic [NUM_BITS-1:0] m1_num_x_ff, m1_num_y_ff;
   logic   m2_valid_ff;
   logic   m2_en;
   dv_type m2_data_ff;
   dv_type m2_data_in;

   logic   dv_in_ready, dv_out_valid, dv_out_ready;
   dv_type dv_out_data;

   // output register
   logic                out_valid_ff;
   logic                out_en;
   logic [ACC_BITS-1:0] out_ax_ff, out_ay_ff, out_ax_in, out_ay_in;
   logic                out_origin_ff, out_sat_ff, out_origin_in, out_sat_in;

   assign out_en = !out_valid_ff || rsp_tready;
   assign dv_out_ready = out_en;
   assign m2_en  = !m2_valid_ff || dv_in_ready;
   assign m1_en  = !m1_valid_ff || m2_en;
   assign sq_out_ready = m1_en;
   assign a3_en  = !a3_valid_ff || sq_in_ready;
   assign a2_en  = !a2_valid_ff || a3_en;
   assign a1_en  = !a1_valid_ff || a2_en;
   assign req_tready = a1_en;

   always_ff @(posedge clock) begin
      if (reset) begin
         a1_valid_ff  <= 1'b0;
         a2_valid_ff  <= 1'b0;
         a3_valid_ff  <= 1'b0;
         m1_valid_ff  <= 1'b0;
         m2_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         if (a1_en) begin
            a1_valid_ff <= req_tvalid;
         end
         if (a2_en) begin
            a2_valid_ff <= a1_valid_ff;
         end
         if (a3_en) begin
            a3_valid_ff <= a2_valid_ff;
         end
         if (m1_en) begin
            m1_valid_ff <= sq_out_valid;
         end
         if (m2_en) begin
            m2_valid_ff <= m1_valid_ff;
         end
         if (out_en) begin
            out_valid_ff <= dv_out_valid;
         end
      end
   end

   assign raw_x = req_tdata[POS_BITS-1:0];
   assign raw_y = req_tdata[2*POS_BITS-1:POS_BITS];

   always_ff @(posedge clock) begin
      if (a1_en) begin
         a1_neg_x_ff <= raw_x[POS_BITS-1];
         a1_neg_y_ff <= raw_y[POS_BITS-1];
         a1_mag_x_ff <= raw_x[POS_BITS-1] ? POS_BITS'(-raw_x) : raw_x;
         a1_mag_y_ff <= raw_y[POS_BITS-1] ? POS_BITS'(-raw_y) : raw_y;
      end
   end

   always_ff @(posedge clock) begin
      if (a2_en) begin
         a2_neg_x_ff  <= a1_neg_x_ff;
         a2_neg_y_ff  <= a1_neg_y_ff;
         a2_zero_x_ff <= a1_mag_x_ff == '0;
         a2_zero_y_ff <= a1_mag_y_ff == '0;
         a2_sq_x_ff   <= R2_BITS'(a1_mag_x_ff) * R2_BITS'(a1_mag_x_ff);
         a2_sq_y_ff   <= R2_BITS'(a1_mag_y_ff) * R2_BITS'(a1_mag_y_ff);
         a2_px_lo_ff  <= PART_BITS'(a1_mag_x_ff) * PART_BITS'(grav_ff[MU_SPLIT-1:0]);
         a2_px_hi_ff  <= PART_BITS'(a1_mag_x_ff) * PART_BITS'(grav_ff[MU_BITS-1:MU_SPLIT]);
         a2_py_lo_ff  <= PART_BITS'(a1_mag_y_ff) * PART_BITS'(grav_ff[MU_SPLIT-1:0]);
         a2_py_hi_ff  <= PART_BITS'(a1_mag_y_ff) * PART_BITS'(grav_ff[MU_BITS-1:MU_SPLIT]);
      end
   end

   always_comb begin
      a3_data_in        = '0;
      a3_data_in.neg_x  = a2_neg_x_ff;
      a3_data_in.neg_y  = a2_neg_y_ff;
      a3_data_in.zero_x = a2_zero_x_ff;
      a3_data_in.zero_y = a2_zero_y_ff;
      a3_data_in.r2     = a2_sq_x_ff + a2_sq_y_ff;
      a3_data_in.rem    = a2_sq_x_ff + a2_sq_y_ff;
      a3_data_in.num_x  = (NUM_BITS'(a2_px_hi_ff) << (MU_SPLIT + FRAC_BITS))
                        + (NUM_BITS'(a2_px_lo_ff) << FRAC_BITS);
      a3_data_in.num_y  = (NUM_BITS'(a2_py_hi_ff) << (MU_SPLIT + FRAC_BITS))
                        + (NUM_BITS'(a2_py_lo_ff) << FRAC_BITS);
   end

   always_ff @(posedge clock) begin
      if (a3_en) begin
         a3_data_ff <= a3_data_in;
      end
   end

   pmga_sqrt_pipe u_sqrt (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a3_valid_ff),
      .in_ready  (sq_in_ready),
      .in_data   (a3_data_ff),
      .out_valid (sq_out_valid),
      .out_ready (sq_out_ready),
      .out_data  (sq_out_data)
   );

   always_ff @(posedge clock) begin
      if (m1_en) begin
         m1_neg_x_ff  <= sq_out_data.neg_x;
         m1_neg_y_ff  <= sq_out_data.neg_y;
         m1_zero_x_ff <= sq_out_data.zero_x;
         m1_zero_y_ff <= sq_out_data.zero_y;
         m1_num_x_ff  <= sq_out_data.num_x;
         m1_num_y_ff  <= sq_out_data.num_y;
         m1_p_lo_ff   <= R2_BITS'(sq_out_data.r2[HALF_BITS-1:0])
                       * R2_BITS'(sq_out_data.root[ROOT_BITS-1:0]);
         m1_p_hi_ff   <= R2_BITS'(sq_out_data.r2[R2_BITS-1:HALF_BITS])
                       * R2_BITS'(sq_out_data.root[ROOT_BITS-1:0]);
      end
   end

   always_comb begin
      m2_data_in        = '0;
      m2_data_in.neg_x  = m1_neg_x_ff;
      m2_data_in.neg_y  = m1_neg_y_ff;
      m2_data_in.zero_x = m1_zero_x_ff;
      m2_data_in.zero_y = m1_zero_y_ff;
      m2_data_in.rem_x  = m1_num_x_ff;
      m2_data_in.rem_y  = m1_num_y_ff;
      m2_data_in.r3     = R3_BITS'(m1_p_lo_ff) + (R3_BITS'(m1_p_hi_ff) << HALF_BITS);
   end

   always_ff @(posedge clock) begin
      if (m2_en) begin
         m2_data_ff <= m2_data_in;
      end
   end

   pmga_div_pipe u_div (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (m2_valid_ff),
      .in_ready  (dv_in_ready),
      .in_data   (m2_data_ff),
      .out_valid (dv_out_valid),
      .out_ready (dv_out_ready),
      .out_data  (dv_out_data)
   );

   // clip, negate for positive coordinates, force zero at the origin
   always_comb begin
      logic [Q_BITS-1:0] lim_x, lim_y, qv_x, qv_y;
      logic              clip_x, clip_y, pos_x, pos_y;
      pos_x  = !dv_out_data.neg_x && !dv_out_data.zero_x;
      pos_y  = !dv_out_data.neg_y && !dv_out_data.zero_y;
      lim_x  = pos_x ? {1'b1, {(Q_BITS-1){1'b0}}} : {1'b0, {(Q_BITS-1){1'b1}}};
      lim_y  = pos_y ? {1'b1, {(Q_BITS-1){1'b0}}} : {1'b0, {(Q_BITS-1){1'b1}}};
      clip_x = dv_out_data.ovf_x || (dv_out_data.q_x > lim_x);
      clip_y = dv_out_data.ovf_y || (dv_out_data.q_y > lim_y);
      qv_x   = clip_x ? lim_x : dv_out_data.q_x;
      qv_y   = clip_y ? lim_y : dv_out_data.q_y;
      out_origin_in = dv_out_data.zero_x && dv_out_data.zero_y;
      if (out_origin_in) begin
         out_ax_in  = '0;
         out_ay_in  = '0;
         out_sat_in = 1'b0;
      end else begin
         out_ax_in  = pos_x ? ACC_BITS'(-qv_x) : qv_x;
         out_ay_in  = pos_y ? ACC_BITS'(-qv_y) : qv_y;
         out_sat_in = clip_x || clip_y;
      end
   end

   always_ff @(posedge clock) begin
      if (out_en) begin
         out_ax_ff     <= out_ax_in;
         out_ay_ff     <= out_ay_in;
         out_origin_ff <= out_origin_in;
         out_sat_ff    <= out_sat_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_ay_ff, out_ax_ff};
   assign rsp_tuser  = {out_sat_ff, out_origin_ff};

   `PMGA_ASSERT_IMPL(a_origin_zero, clock, reset, rsp_tvalid && rsp_tuser[0], rsp_tdata == '0 && !rsp_tuser[1])
   `PMGA_ASSERT_IMPL(a_sat_extreme, clock, reset, rsp_tvalid && rsp_tuser[1], rsp_tdata[31:0] == 32'h7fff_ffff || rsp_tdata[31:0] == 32'h8000_0000 || rsp_tdata[63:32] == 32'h7fff_ffff || rsp_tdata[63:32] == 32'h8000_0000)
   `PMGA_ASSERT_NEXT(a_reset_empty, clock, 1'b0, reset, !rsp_tvalid && !m2_valid_ff && !a1_valid_ff)

endmodule

### tb/point_mass_gravity_accel_unit_tb.sv
// testbench for the point mass gravity acceleration unit: random and directed positions, scoreboarded
module point_mass_gravity_accel_unit_tb;
   import pmga_pkg::*;

   typedef struct {
      logic [31:0] acc_x;
      logic [31:0] acc_y;
      logic        origin;
      logic        sat;
   } accel_type;

   class accel_scoreboard;
      logic [MU_BITS-1:0] mu;
      accel_type          pending_q[$];
      int                 mismatches;
      int                 checked;

      function new();
         mu = MU_RESET;
         mismatches = 0;
         checked = 0;
      endfunction

      function logic [63:0] floor_root(logic [63:0] n);
         logic [63:0] res;
         logic [63:0] t;
         res = 0;
         for (int i = 31; i >= 0; i--) begin
            t = res | (64'd1 << i);
            if (t * t <= n) res = t;
         end
         return res;
      endfunction

      // quotient truncated toward zero, clipped to the signed 32-bit range
      function logic [31:0] axis_accel(logic signed [31:0] p, logic [127:0] r3, ref logic sat);
         logic [127:0] mag;
         logic [127:0] quo;
         logic [127:0] lim;
         logic [31:0]  q;
         mag = (p < 0) ? 128'(-64'(p)) : 128'(p);
         if (mag == 0 || mu == 0) return 32'd0;
         lim = (p > 0) ? 128'h8000_0000 : 128'h7FFF_FFFF;
         quo = ((128'(mu) * mag) << FRAC_BITS) / r3;
         if (quo > lim) begin
            q = lim[31:0];
            sat = 1'b1;
         end else begin
            q = quo[31:0];
         end
         return (p > 0) ? (32'd0 - q) : q;
      endfunction

      function void note_position(logic signed [31:0] x, logic signed [31:0] y);
         accel_type    e;
         logic [63:0]  ax, ay, r2, r;
         logic [127:0] r3;
         e.sat = 1'b0;
         if (x == 0 && y == 0) begin
            e.acc_x = 0;
            e.acc_y = 0;
            e.origin = 1'b1;
         end else begin
            ax = (x < 0) ? -64'(x) : 64'(x);
            ay = (y < 0) ? -64'(y) : 64'(y);
            r2 = ax * ax + ay * ay;
            r = floor_root(r2);
            r3 = 128'(r2) * 128'(r);
            e.origin = 1'b0;
            e.acc_x = axis_accel(x, r3, e.sat);
            e.acc_y = axis_accel(y, r3, e.sat);
         end
         pending_q.push_back(e);
      endfunction

      function void check_accel(logic [63:0] data, logic [1:0] user);
         accel_type e;
         if (pending_q.size() == 0) begin
            mismatches++;
            if (mismatches <= 10) $display("unexpected response data=%h user=%b", data, user);
            return;
         end
         e = pending_q.pop_front();
         checked++;
         if (data[31:0] !== e.acc_x || data[63:32] !== e.acc_y ||
             user[0] !== e.origin || user[1] !== e.sat) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch #%0d: exp ax=%h ay=%h org=%b sat=%b got ax=%h ay=%h org=%b sat=%b",
                        checked, e.acc_x, e.acc_y, e.origin, e.sat,
                        data[31:0], data[63:32], user[0], user[1]);
         end
      endfunction
   endclass

   logic               clock = 0;
   logic               reset = 1;
   logic               csr_valid = 0;
   logic               csr_ready;
   logic [MU_BITS-1:0] csr_data = 0;
   logic               req_tvalid = 0;
   logic               req_tready;
   logic [63:0]        req_tdata = 0;   // pos_x, pos_y
   logic               rsp_tvalid;
   logic               rsp_tready = 0;
   logic [63:0]        rsp_tdata;       // accel_x, accel_y
   logic [1:0]         rsp_tuser;       // at_origin, saturated

   accel_scoreboard sb = new();
   int  burst_left = 0;
   bit  hold_request = 0;
   int  hold_cnt = 0;
   int  cycles = 0;
   int  sent = 0;

   point_mass_gravity_accel_unit dut (
      .clock(clock), .reset(reset),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always begin
      #5 clock = 1;
      #5 clock = 0;
   end

   always @(posedge clock) begin
      cycles++;
      if (cycles > 400000) begin
         $display("timeout after %0d cycles", cycles);
         $display("point_mass_gravity_accel_unit_tb: FAIL");
         $finish;
      end
   end

   // receiver: long hold-off on request, otherwise a stall pattern that changes over time
   always @(posedge clock) begin
      if (hold_request && hold_cnt == 0) begin
         hold_cnt <= 400;
         hold_request <= 0;
         rsp_tready <= 1'b0;
      end else if (hold_cnt > 0) begin
         hold_cnt <= hold_cnt - 1;
         rsp_tready <= 1'b0;
      end else if ((cycles / 500) % 3 == 0) begin
         rsp_tready <= 1'b1;
      end else begin
         rsp_tready <= ($urandom_range(0, 3) != 0);
      end
   end

   always @(posedge clock)
      if (!reset && rsp_tvalid && rsp_tready) sb.check_accel(rsp_tdata, rsp_tuser);

   task automatic send_position(logic signed [31:0] x, logic signed [31:0] y);
      req_tvalid <= 1'b1;
      req_tdata <= {y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      sb.note_position(x, y);
      sent++;
      if (burst_left > 0) begin
         burst_left--;
      end else begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 12)) @(posedge clock);
         burst_left = $urandom_range(0, 40);
      end
   endtask

   task automatic write_mu(logic [MU_BITS-1:0] v);
      csr_valid <= 1'b1;
      csr_data <= v;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
      csr_valid <= 1'b0;
      sb.mu = v;
   endtask

   task automatic drain();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (sb.pending_q.size() != 0) @(posedge clock);
      repeat (100) @(posedge clock);
   endtask

   function automatic logic [31:0] rand_coord();
      logic [31:0] r;
      r = $urandom;
      if ($urandom_range(0, 9) == 0) return 32'd0;
      return $signed(r) >>> $urandom_range(0, 31);
   endfunction

   task automatic directed_positions();
      send_position(0, 0);
      send_position(1, 0);
      send_position(-1, 0);
      send_position(0, 1);
      send_position(0, -1);
      send_position(1, 1);
      send_position(-1, -1);
      send_position(32'h8000_0000, 32'h8000_0000);
      send_position(32'h7FFF_FFFF, 32'h7FFF_FFFF);
      send_position(32'h8000_0000, 0);
      send_position(0, 32'h7FFF_FFFF);
      send_position(6371000, -6371000);
      send_position(42164000, 0);
      send_position(-300, 400);
   endtask

   initial begin
      logic [MU_BITS-1:0] mu_list[6];
      mu_list[0] = MU_RESET;
      mu_list[1] = '0;
      mu_list[2] = '1;
      mu_list[3] = MU_BITS'(1);
      mu_list[4] = MU_BITS'({$urandom, $urandom});
      mu_list[5] = MU_RESET;
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      for (int ph = 0; ph < 6; ph++) begin
         if (ph > 0) write_mu(mu_list[ph]);
         directed_positions();
         for (int i = 0; i < 70; i++) begin
            if (ph == 2 && i == 20) hold_request = 1;
            send_position(rand_coord(), rand_coord());
         end
         drain();
      end
      $display("%0d positions sent over six mu settings (zero, full scale, one, default, random),",
               sent);
      $display("%0d responses checked, %0d mismatches", sb.checked, sb.mismatches);
      if (sb.mismatches == 0 && sb.pending_q.size() == 0)
         $display("point_mass_gravity_accel_unit_tb: PASS");
      else
         $display("point_mass_gravity_accel_unit_tb: FAIL");
      $finish;
   end
endmodule

### filelist.f
+incdir+rtl
rtl/pmga_pkg.sv
rtl/pmga_sqrt_pipe.sv
rtl/pmga_div_pipe.sv
rtl/point_mass_gravity_accel_unit.sv
tb/point_mass_gravity_accel_unit_tb.sv
